@@ rtl/ngga_pkg.sv @@
package ngga_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [1:0] VD_VALID    = 2'd0;
  localparam logic [1:0] VD_PREFIX   = 2'd1;
  localparam logic [1:0] VD_CHECKSUM = 2'd2;

  typedef struct packed {
    logic       fld_vld;
    logic       fld_end;
    logic [3:0] fld_num;
    logic [7:0] fld_char;
    logic       vd_vld;
    logic [1:0] vd;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/ngga_in_if.sv @@
interface ngga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ rtl/ngga_out_if.sv @@
interface ngga_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [3:0] field_number;
  logic [7:0] field_char;
  logic [1:0] verdict;
  logic       run_last;

  modport source (output valid, output result_kind, output field_number, output field_char,
                  output verdict, output run_last, input ready);
  modport sink (input valid, input result_kind, input field_number, input field_char,
                input verdict, input run_last, output ready);
endinterface

@@ rtl/ngga_front.sv @@
module ngga_front #(
  parameter int FIELD_COUNT = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  ngga_in_if.sink           in_ch,
  input  ngga_pkg::q_stat_t q_stat,
  output logic              push,
  output ngga_pkg::entry_t  push_ent
);

  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_FIELDS = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [3:0] FIELD_LIMIT = 4'(FIELD_COUNT);

  function automatic logic [7:0] prefix_char(input logic [2:0] p);
    logic [7:0] c;
    unique case (p)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h41;
      3'd6:    c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  logic [2:0] pos_r, pos_nxt;
  logic       pg_r, pg_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       star_r, star_nxt;
  logic [3:0] fld_r, fld_nxt;
  logic       acc;
  logic [4:0] hx;

  assign in_ch.ready = !q_stat.full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign hx          = hex_digit(in_ch.data_byte);

  always_comb begin
    pos_nxt   = pos_r;
    pg_nxt    = pg_r;
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    sum_nxt   = sum_r;
    star_nxt  = star_r;
    fld_nxt   = fld_r;
    push_ent  = '0;
    if (acc) begin
      unique case (phase_r)
        PH_PREFIX: begin
          if (pos_r != 3'd7) begin
            if (pos_r != 3'd0) xor_nxt = xor_r ^ in_ch.data_byte;
            if (in_ch.data_byte != prefix_char(pos_r)) pg_nxt = 1'b0;
            pos_nxt = pos_r + 3'd1;
          end
          if (pos_nxt == 3'd7) phase_nxt = PH_FIELDS;
        end
        PH_FIELDS: begin
          if (in_ch.data_byte == 8'h2A) begin
            star_nxt  = 1'b1;
            phase_nxt = PH_DIGITS;
          end else begin
            xor_nxt = xor_r ^ in_ch.data_byte;
            if (fld_r < FIELD_LIMIT) begin
              push_ent.fld_num = fld_r;
              if (in_ch.data_byte == 8'h2C) begin
                push_ent.fld_vld = pg_r;
                push_ent.fld_end = 1'b1;
                fld_nxt          = fld_r + 4'd1;
              end else begin
                push_ent.fld_vld  = pg_r;
                push_ent.fld_char = in_ch.data_byte;
              end
            end
          end
        end
        PH_DIGITS: begin
          if (hx[4]) sum_nxt = {sum_r[3:0], hx[3:0]};
          else phase_nxt = PH_DONE;
        end
        PH_DONE: begin
        end
      endcase
      if (in_ch.final_byte) begin
        push_ent.vd_vld = 1'b1;
        if (pos_nxt != 3'd7 || !pg_nxt) push_ent.vd = ngga_pkg::VD_PREFIX;
        else if (!star_nxt || xor_nxt != sum_nxt) push_ent.vd = ngga_pkg::VD_CHECKSUM;
        else push_ent.vd = ngga_pkg::VD_VALID;
        pos_nxt   = 3'd0;
        pg_nxt    = 1'b1;
        phase_nxt = PH_PREFIX;
        xor_nxt   = 8'd0;
        sum_nxt   = 8'd0;
        star_nxt  = 1'b0;
        fld_nxt   = 4'd0;
      end
    end
  end

  assign push = push_ent.fld_vld || push_ent.vd_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 3'd0;
      pg_r    <= 1'b1;
      phase_r <= PH_PREFIX;
      xor_r   <= 8'd0;
      sum_r   <= 8'd0;
      star_r  <= 1'b0;
      fld_r   <= 4'd0;
    end else begin
      pos_r   <= pos_nxt;
      pg_r    <= pg_nxt;
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      sum_r   <= sum_nxt;
      star_r  <= star_nxt;
      fld_r   <= fld_nxt;
    end
  end

endmodule

@@ rtl/ngga_queue.sv @@
module ngga_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ngga_pkg::entry_t  push_ent,
  input  logic              pop,
  output ngga_pkg::entry_t  head,
  output ngga_pkg::q_stat_t q_stat
);

  localparam int AW = ngga_pkg::QUEUE_AW;

  ngga_pkg::entry_t mem_r [ngga_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (cnt_r == (AW+1)'(ngga_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/ngga_back.sv @@
module ngga_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ngga_pkg::entry_t  head,
  input  ngga_pkg::q_stat_t q_stat,
  output logic              pop,
  ngga_out_if.source        out_ch
);

  logic       vld_r, vld_nxt;
  logic       half_r, half_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [3:0] num_r, num_nxt;
  logic [7:0] char_r, char_nxt;
  logic [1:0] vd_r, vd_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt  = vld_r && !out_ch.ready;
    half_nxt = half_r;
    kind_nxt = kind_r;
    num_nxt  = num_r;
    char_nxt = char_r;
    vd_nxt   = vd_r;
    last_nxt = last_r;
    pop      = 1'b0;
    if (load && !q_stat.empty) begin
      vld_nxt = 1'b1;
      if (head.fld_vld && !half_r) begin
        kind_nxt = head.fld_end ? ngga_pkg::KIND_END : ngga_pkg::KIND_CHAR;
        num_nxt  = head.fld_num;
        char_nxt = head.fld_end ? 8'd0 : head.fld_char;
        vd_nxt   = ngga_pkg::VD_VALID;
        last_nxt = !head.vd_vld;
        half_nxt = head.vd_vld;
        pop      = !head.vd_vld;
      end else begin
        kind_nxt = ngga_pkg::KIND_VERDICT;
        num_nxt  = 4'd0;
        char_nxt = 8'd0;
        vd_nxt   = head.vd;
        last_nxt = 1'b1;
        half_nxt = 1'b0;
        pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      half_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      half_r <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    num_r  <= num_nxt;
    char_r <= char_nxt;
    vd_r   <= vd_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.result_kind  = kind_r;
  assign out_ch.field_number = num_r;
  assign out_ch.field_char   = char_r;
  assign out_ch.verdict      = vd_r;
  assign out_ch.run_last     = last_r;

endmodule

@@ rtl/nmea_gga_sentence_parser.sv @@
// GGA sentence parser. Feed one sentence byte per item on in_ch, starting at the dollar sign,
// with final_byte set on the last byte. One byte is accepted every cycle while the four-entry
// queue between the classifier and the output stage has room; each byte yields zero, one or two
// result items, and the output stage sends one result item per cycle while the receiver takes
// them, so a byte with a field result and a verdict yields two items in turn. Each result passes
// through the queue and then the output register. Field characters and field ends are provisional
// and must be dropped unless the verdict item that closes the sentence reports valid.
module nmea_gga_sentence_parser #(
  parameter int FIELD_COUNT = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  ngga_in_if.sink    in_ch,
  ngga_out_if.source out_ch
);

  logic              push;
  logic              pop;
  ngga_pkg::entry_t  push_ent;
  ngga_pkg::entry_t  head;
  ngga_pkg::q_stat_t q_stat;

  ngga_front #(
    .FIELD_COUNT(FIELD_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_ent (push_ent)
  );

  ngga_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  ngga_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind == ngga_pkg::KIND_VERDICT) |-> out_ch.run_last)
    else $error("verdict item not marked last");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind != ngga_pkg::KIND_VERDICT)
      |-> (out_ch.field_number < 4'(FIELD_COUNT)))
    else $error("field number out of range");

endmodule
